// ===== hw/rtl/iir_direct_form2_transposed_assert.svh =====
// Assertion macros for the IIR filter checker.
// The using scope provides clk and rst_n.
`ifndef IIR_DIRECT_FORM2_TRANSPOSED_ASSERT_SVH
`define IIR_DIRECT_FORM2_TRANSPOSED_ASSERT_SVH

// Same-cycle implication.
`define IIRDF2T_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define IIRDF2T_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/iirdf2t_pkg.sv =====
`default_nettype none

package iirdf2t_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 32;
    localparam int ACC_BITS        = 64;
    localparam int FB_BITS         = 32;
    localparam int FB_FRAC         = 24;
    localparam int NUM_COEFS       = 9;
    localparam int COEF_IDX_BITS   = 4;
    localparam int A_BASE          = 5;
    localparam int REG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 64;
    localparam int K_BITS          = 2;
    localparam int MAX_ORDER_WORDS = 4;

    typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t REG_COEF_B0_B1 = 3'd0;
    localparam reg_idx_t REG_COEF_B2_B3 = 3'd1;
    localparam reg_idx_t REG_COEF_B4_A1 = 3'd2;
    localparam reg_idx_t REG_COEF_A2_A3 = 3'd3;
    localparam reg_idx_t REG_COEF_A4    = 3'd4;

    // b0 = 1.0 in Q4.28
    localparam logic [CFG_DATA_BITS-1:0] COEF_B0_B1_RESET = 64'h0000_0000_1000_0000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          start_of_signal;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_SUM_Y,
        ST_MUL_B,
        ST_MUL_A,
        ST_WRITE
    } step_t;

    typedef struct packed {
        step_t             step;
        logic [K_BITS-1:0] k;
        logic              take;
        logic              load_out;
    } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iirdf2t_mul.sv =====
`default_nettype none

module iirdf2t_mul (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  wire logic signed [iirdf2t_pkg::COEF_BITS-1:0] a,
    input  wire logic signed [iirdf2t_pkg::COEF_BITS-1:0] b,
    output logic signed [iirdf2t_pkg::ACC_BITS-1:0]       p
);

    logic signed [iirdf2t_pkg::ACC_BITS-1:0] p_reg;
    logic signed [iirdf2t_pkg::ACC_BITS-1:0] p_next;

    assign p_next = iirdf2t_pkg::ACC_BITS'(a) * iirdf2t_pkg::ACC_BITS'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/iirdf2t_seq.sv =====
`default_nettype none

module iirdf2t_seq #(
    parameter int ORDER = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output iirdf2t_pkg::seq_ctrl_t     ctrl
);

    localparam logic [iirdf2t_pkg::K_BITS-1:0] K_LAST = iirdf2t_pkg::K_BITS'(ORDER - 1);

    iirdf2t_pkg::step_t              state_reg, state_next;
    logic [iirdf2t_pkg::K_BITS-1:0]  k_reg, k_next;
    logic                            rv_reg, rv_next;
    logic                            out_free;
    logic                            load_out;
    logic                            take;

    assign out_free = !rv_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            iirdf2t_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = iirdf2t_pkg::ST_MUL_B0;
                end
            end
            iirdf2t_pkg::ST_MUL_B0:
            begin
                state_next = iirdf2t_pkg::ST_SUM_Y;
            end
            iirdf2t_pkg::ST_SUM_Y:
            begin
                state_next = iirdf2t_pkg::ST_MUL_B;
                k_next     = '0;
            end
            iirdf2t_pkg::ST_MUL_B:
            begin
                state_next = iirdf2t_pkg::ST_MUL_A;
            end
            iirdf2t_pkg::ST_MUL_A:
            begin
                if (k_reg == K_LAST)
                begin
                    state_next = iirdf2t_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = iirdf2t_pkg::ST_MUL_B;
                    k_next     = k_reg + iirdf2t_pkg::K_BITS'(1);
                end
            end
            iirdf2t_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = iirdf2t_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iirdf2t_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == iirdf2t_pkg::ST_IDLE);
        take       = item_ready && item_valid;
        load_out   = (state_reg == iirdf2t_pkg::ST_WRITE) && out_free;
        if (load_out)
        begin
            rv_next = 1'b1;
        end
        else if (result_ready)
        begin
            rv_next = 1'b0;
        end
        else
        begin
            rv_next = rv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iirdf2t_pkg::ST_IDLE;
            k_reg     <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            rv_reg    <= rv_next;
        end
    end

    assign result_valid  = rv_reg;
    assign ctrl.step     = state_reg;
    assign ctrl.k        = k_reg;
    assign ctrl.take     = take;
    assign ctrl.load_out = load_out;

endmodule

`default_nettype wire

// ===== hw/rtl/iir_direct_form2_transposed.sv =====
// An item is taken only in idle; the sequencer then steps through MUL_B0, SUM_Y,
//   ORDER pairs of MUL_B and MUL_A, and WRITE, which loads the result register once
//   the previous result is taken or being taken. No new item is taken before WRITE,
//   as the one shared 32x32 multiplier forms the 2*ORDER+1 products of each sample.
// Reset: b0 = 1.0 and all other coefficients zero, delay words zero, no result.
`default_nettype none

module iir_direct_form2_transposed #(
    parameter int ORDER          = 4,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_wr_en,
    input  wire iirdf2t_pkg::reg_idx_t                       cfg_index,
    input  wire logic [iirdf2t_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  wire logic                                        item_valid,
    output logic                                             item_ready,
    input  wire iirdf2t_pkg::item_t                          item,
    output logic                                             result_valid,
    input  wire logic                                        result_ready,
    output iirdf2t_pkg::result_t                             result
);

    localparam int ACC_FRAC  = iirdf2t_pkg::SAMPLE_BITS - 1 + COEF_FRAC_BITS;
    localparam int FB_SHIFT  = ACC_FRAC - iirdf2t_pkg::FB_FRAC;
    localparam int AY_SHIFT  = COEF_FRAC_BITS + iirdf2t_pkg::FB_FRAC - ACC_FRAC;
    localparam int AB        = iirdf2t_pkg::ACC_BITS;
    localparam int CB        = iirdf2t_pkg::COEF_BITS;
    localparam int SB        = iirdf2t_pkg::SAMPLE_BITS;
    localparam int FBB       = iirdf2t_pkg::FB_BITS;
    localparam int KB        = iirdf2t_pkg::K_BITS;
    localparam logic [KB:0] ORDER_W = (KB + 1)'(ORDER);

    iirdf2t_pkg::seq_ctrl_t ctrl;

    logic [iirdf2t_pkg::CFG_DATA_BITS-1:0] coef_b0_b1_reg;
    logic [iirdf2t_pkg::CFG_DATA_BITS-1:0] coef_b2_b3_reg;
    logic [iirdf2t_pkg::CFG_DATA_BITS-1:0] coef_b4_a1_reg;
    logic [iirdf2t_pkg::CFG_DATA_BITS-1:0] coef_a2_a3_reg;
    logic [CB-1:0]                         coef_a4_reg;

    logic signed [CB-1:0]                  coef_w [iirdf2t_pkg::NUM_COEFS];
    logic [iirdf2t_pkg::COEF_IDX_BITS-1:0] coef_idx;
    logic signed [CB-1:0]                  mul_a;
    logic signed [CB-1:0]                  mul_b;
    logic                                  mul_en;
    logic signed [AB-1:0]                  prod;

    logic signed [SB-1:0]  x_reg;
    logic signed [AB-1:0]  y_reg;
    logic signed [FBB-1:0] yfb_reg, yfb_next;
    logic [AB-1:0]         acc_reg;
    logic [AB-1:0]         z_reg [iirdf2t_pkg::MAX_ORDER_WORDS];
    iirdf2t_pkg::result_t  res_reg, res_next;
    iirdf2t_pkg::result_t  result_reg;

    logic signed [AB-1:0] fb_asr;
    logic [AB-1:0]        fb_rnd;
    logic                 fb_sat;
    logic signed [AB-1:0] out_asr;
    logic [AB-1:0]        out_rnd;
    logic                 out_sat;
    logic signed [AB-1:0] ay_asr;
    logic [AB-1:0]        z_new;
    logic [KB:0]          j1;
    logic [AB-1:0]        z_follow;

    iirdf2t_seq #(
        .ORDER(ORDER)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ctrl         (ctrl)
    );

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_b1_reg <= iirdf2t_pkg::COEF_B0_B1_RESET;
            coef_b2_b3_reg <= '0;
            coef_b4_a1_reg <= '0;
            coef_a2_a3_reg <= '0;
            coef_a4_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                iirdf2t_pkg::REG_COEF_B0_B1: coef_b0_b1_reg <= cfg_data;
                iirdf2t_pkg::REG_COEF_B2_B3: coef_b2_b3_reg <= cfg_data;
                iirdf2t_pkg::REG_COEF_B4_A1: coef_b4_a1_reg <= cfg_data;
                iirdf2t_pkg::REG_COEF_A2_A3: coef_a2_a3_reg <= cfg_data;
                iirdf2t_pkg::REG_COEF_A4:    coef_a4_reg    <= cfg_data[CB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // b0..b4 are words 0..4, a1..a4 are words 5..8
    assign coef_w[0] = coef_b0_b1_reg[CB-1:0];
    assign coef_w[1] = coef_b0_b1_reg[2*CB-1:CB];
    assign coef_w[2] = coef_b2_b3_reg[CB-1:0];
    assign coef_w[3] = coef_b2_b3_reg[2*CB-1:CB];
    assign coef_w[4] = coef_b4_a1_reg[CB-1:0];
    assign coef_w[5] = coef_b4_a1_reg[2*CB-1:CB];
    assign coef_w[6] = coef_a2_a3_reg[CB-1:0];
    assign coef_w[7] = coef_a2_a3_reg[2*CB-1:CB];
    assign coef_w[8] = coef_a4_reg;

    always_comb
    begin
        coef_idx = '0;
        mul_b    = CB'(x_reg);
        mul_en   = 1'b0;
        unique case (ctrl.step)
            iirdf2t_pkg::ST_MUL_B0:
            begin
                mul_en = 1'b1;
            end
            iirdf2t_pkg::ST_MUL_B:
            begin
                coef_idx = iirdf2t_pkg::COEF_IDX_BITS'(ctrl.k) + 4'd1;
                mul_en   = 1'b1;
            end
            iirdf2t_pkg::ST_MUL_A:
            begin
                coef_idx = iirdf2t_pkg::COEF_IDX_BITS'(ctrl.k)
                         + iirdf2t_pkg::COEF_IDX_BITS'(iirdf2t_pkg::A_BASE);
                mul_b    = yfb_reg;
                mul_en   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_a = coef_w[coef_idx];

    iirdf2t_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // feedback value: y rounded to Q8.24, saturated to 32 bits
    assign fb_asr = y_reg >>> FB_SHIFT;
    assign fb_rnd = fb_asr + AB'(y_reg[FB_SHIFT-1]);
    assign fb_sat = (fb_rnd[AB-1:FBB-1] != '0) && (fb_rnd[AB-1:FBB-1] != '1);

    // output: y rounded to sample precision, saturated
    assign out_asr = y_reg >>> COEF_FRAC_BITS;
    assign out_rnd = out_asr + AB'(y_reg[COEF_FRAC_BITS-1]);
    assign out_sat = (out_rnd[AB-1:SB-1] != '0) && (out_rnd[AB-1:SB-1] != '1);

    always_comb
    begin
        if (fb_sat)
        begin
            yfb_next = fb_rnd[AB-1] ? {1'b1, {(FBB-1){1'b0}}} : {1'b0, {(FBB-1){1'b1}}};
        end
        else
        begin
            yfb_next = fb_rnd[FBB-1:0];
        end
        if (out_sat)
        begin
            res_next.sample_out = out_rnd[AB-1] ? {1'b1, {(SB-1){1'b0}}}
                                                : {1'b0, {(SB-1){1'b1}}};
        end
        else
        begin
            res_next.sample_out = out_rnd[SB-1:0];
        end
        res_next.saturated = fb_sat || out_sat;
    end

    // z = acc - round(a*yfb); acc - asr - r = acc + ~asr + !r
    assign ay_asr   = prod >>> AY_SHIFT;
    assign z_new    = acc_reg + ~ay_asr + AB'(!prod[AY_SHIFT-1]);
    assign j1       = {1'b0, ctrl.k} + (KB + 1)'(1);
    assign z_follow = (j1 < ORDER_W) ? z_reg[j1[KB-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iirdf2t_pkg::MAX_ORDER_WORDS; i++)
            begin
                z_reg[i] <= '0;
            end
        end
        else if (ctrl.take && item.start_of_signal)
        begin
            for (int i = 0; i < iirdf2t_pkg::MAX_ORDER_WORDS; i++)
            begin
                z_reg[i] <= '0;
            end
        end
        else if (ctrl.step == iirdf2t_pkg::ST_MUL_B && ctrl.k != '0)
        begin
            z_reg[ctrl.k - KB'(1)] <= z_new;
        end
        else if (ctrl.step == iirdf2t_pkg::ST_WRITE)
        begin
            z_reg[ctrl.k] <= z_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            x_reg <= item.sample_in;
        end
        if (ctrl.step == iirdf2t_pkg::ST_SUM_Y)
        begin
            y_reg <= prod + z_reg[0];
        end
        if (ctrl.step == iirdf2t_pkg::ST_MUL_B)
        begin
            yfb_reg <= yfb_next;
            res_reg <= res_next;
        end
        if (ctrl.step == iirdf2t_pkg::ST_MUL_A)
        begin
            acc_reg <= prod + z_follow;
        end
        if (ctrl.load_out)
        begin
            result_reg <= res_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/iirdf2t_chk.sv =====
`default_nettype none

`include "iir_direct_form2_transposed_assert.svh"

module iirdf2t_chk (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire iirdf2t_pkg::result_t result
);

    `IIRDF2T_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

    `IIRDF2T_ASSERT_NXT(a_busy_after_take, item_valid && item_ready, !item_ready ##1 !item_ready, "ready too soon after transfer")

    `IIRDF2T_ASSERT_IMP(a_result_from_busy, $rose(result_valid), $past(!item_ready), "result appeared while idle")

    `IIRDF2T_ASSERT_NXT(a_no_result_on_take, item_valid && item_ready && !result_valid, !result_valid, "result too soon after transfer")

endmodule

bind iir_direct_form2_transposed iirdf2t_chk u_iirdf2t_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ===== test/iir_direct_form2_transposed_test.sv =====
`default_nettype none

module iir_direct_form2_transposed_test;

    import iirdf2t_pkg::*;

    localparam int FILTER_ORDER = 4;
    localparam int COEF_FRAC    = 28;
    localparam int ACC_FRAC     = SAMPLE_BITS - 1 + COEF_FRAC;
    localparam int FB_SHIFT     = ACC_FRAC - FB_FRAC;
    localparam int AY_SHIFT     = COEF_FRAC + FB_FRAC - ACC_FRAC;
    localparam int NUM_REGS     = REG_COEF_A4 + 1;
    localparam int DRAIN_CYCLES = 2 * FILTER_ORDER + 8;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 125;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    reg_idx_t                 cfg_index = REG_COEF_B0_B1;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     item_valid = 1'b0;
    logic                     item_ready;
    item_t                    item = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result;

    // filter state as the predictor sees it
    logic [CFG_DATA_BITS-1:0] coef_reg [NUM_REGS];
    longint                   delay_word [FILTER_ORDER];
    logic [COEF_BITS-1:0]     taps [NUM_COEFS];

    item_t   samples_to_send [$];
    result_t predicted_outputs [$];

    int src_gap_max = 7;
    int snk_gap_max = 7;
    int src_wait = 0;
    int snk_wait = 0;
    int snk_draw;
    int holds_asked = 0;
    int holds_served = 0;
    int stall_cycles = 0;
    int errors = 0;

    iir_direct_form2_transposed #(
        .ORDER          (FILTER_ORDER),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint coef_at(int i);
        logic [CFG_DATA_BITS-1:0] w;
        w = coef_reg[i >> 1];
        if (i[0])
            return longint'($signed(w[63:32]));
        return longint'($signed(w[31:0]));
    endfunction

    // arithmetic shift right, rounding half up
    function automatic longint round_sh(longint v, int s);
        return (v >>> s) + longint'(v[s-1]);
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic result_t run_filter(item_t it);
        longint  x;
        longint  y;
        longint  full;
        longint  yfb;
        longint  o;
        longint  next;
        bit      clipped;
        int      k;
        result_t r;
        x = longint'($signed(it.sample_in));
        if (it.start_of_signal)
            for (k = 0; k < FILTER_ORDER; k++)
                delay_word[k] = 0;
        y = coef_at(0) * x + delay_word[0];
        full = round_sh(y, FB_SHIFT);
        yfb = clip(full, FB_BITS);
        clipped = (yfb != full);
        for (k = 1; k <= FILTER_ORDER; k++)
        begin
            next = (k < FILTER_ORDER) ? delay_word[k] : 0;
            delay_word[k-1] = coef_at(k) * x + next
                              - round_sh(coef_at(A_BASE + k - 1) * yfb, AY_SHIFT);
        end
        full = round_sh(y, COEF_FRAC);
        o = clip(full, SAMPLE_BITS);
        clipped = clipped || (o != full);
        r.sample_out = o[SAMPLE_BITS-1:0];
        r.saturated = clipped;
        return r;
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (predicted_outputs.size() == 0)
        begin
            $error("unexpected transfer: sample_out %0d saturated %0b",
                   got.sample_out, got.saturated);
            errors++;
            return;
        end
        want = predicted_outputs.pop_front();
        if (got.sample_out !== want.sample_out)
        begin
            $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
            errors++;
        end
        if (got.saturated !== want.saturated)
        begin
            $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            src_wait <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                predicted_outputs = {predicted_outputs, run_filter(item)};
            if (!item_valid || item_ready)
            begin
                if (src_wait > 0)
                begin
                    src_wait <= src_wait - 1;
                    item_valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    item <= samples_to_send.pop_front();
                    item_valid <= 1'b1;
                    src_wait <= $urandom_range(0, src_gap_max);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            snk_wait <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (holds_served != holds_asked)
            begin
                holds_served <= holds_asked;
                snk_wait <= LONG_HOLD;
                result_ready <= 1'b0;
            end
            else if (result_valid && result_ready)
            begin
                snk_draw = $urandom_range(0, snk_gap_max);
                snk_wait <= snk_draw;
                result_ready <= (snk_draw == 0);
            end
            else if (snk_wait > 0)
            begin
                snk_wait <= snk_wait - 1;
                result_ready <= (snk_wait == 1);
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("iir_direct_form2_transposed test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || item_valid || predicted_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_COEF_A4)
            coef_reg[idx] = {32'b0, val[31:0]};
        else if (idx < REG_COEF_A4)
            coef_reg[idx] = val;
    endtask

    // upper half of the a4 write and the unused indexes carry junk
    task automatic program_taps();
        int i;
        write_reg(REG_COEF_B0_B1, {taps[1], taps[0]});
        write_reg(REG_COEF_B2_B3, {taps[3], taps[2]});
        write_reg(REG_COEF_B4_A1, {taps[5], taps[4]});
        write_reg(REG_COEF_A2_A3, {taps[7], taps[6]});
        write_reg(REG_COEF_A4, {$urandom, taps[8]});
        for (i = REG_COEF_A4 + 1; i < (1 << REG_IDX_BITS); i++)
            write_reg(reg_idx_t'(i), {$urandom, $urandom});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_sample(logic [SAMPLE_BITS-1:0] s, bit sos);
        item_t it;
        it.sample_in = s;
        it.start_of_signal = sos;
        samples_to_send = {samples_to_send, it};
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_coef(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    initial
    begin
        int p;
        int n;
        logic [COEF_BITS-1:0] ext;

        for (n = 0; n < NUM_REGS; n++)
            coef_reg[n] = '0;
        coef_reg[REG_COEF_B0_B1] = COEF_B0_B1_RESET;
        for (n = 0; n < FILTER_ORDER; n++)
            delay_word[n] = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients pass the input straight through
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h5555, 1'b0);
        queue_sample(16'hAAAA, 1'b0);
        wait_drained();

        // b0 = 0.5: odd samples land on half an LSB
        taps = '{32'h0800_0000, 0, 0, 0, 0, 0, 0, 0, 0};
        program_taps();
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0003, 1'b0);
        queue_sample(16'hFFFD, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b0);
        wait_drained();

        // four real poles at 0.5, DC gain 16: full-scale steps clip the output
        taps = '{32'h0100_0000, 32'h0400_0000, 32'h0600_0000, 32'h0400_0000,
                 32'h0100_0000, 32'hE000_0000, 32'h1800_0000, 32'hF800_0000,
                 32'h0100_0000};
        program_taps();
        queue_sample(16'h7FFF, 1'b1);
        for (n = 0; n < 5; n++)
            queue_sample(16'h7FFF, 1'b0);
        for (n = 0; n < 4; n++)
            queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0001, 1'b1);
        wait_drained();

        for (p = 0; p < 12; p++)
        begin
            case (p % 3)
                0:
                    for (n = 0; n < NUM_COEFS; n++)
                        taps[n] = $urandom;
                1:
                    for (n = 0; n < NUM_COEFS; n++)
                        taps[n] = (n < A_BASE) ? rand_coef(1 << 27) : rand_coef(1 << 25);
                default:
                begin
                    case (p / 3)
                        0: ext = 32'h8000_0000;
                        1: ext = 32'h7FFF_FFFF;
                        2: ext = 32'hFFFF_FFFF;
                        default: ext = 32'h0000_0000;
                    endcase
                    for (n = 0; n < NUM_COEFS; n++)
                        taps[n] = ext;
                end
            endcase
            program_taps();
            case (p % 4)
                0: begin src_gap_max = 7; snk_gap_max = 7; end
                1: begin src_gap_max = 0; snk_gap_max = 0; end
                2: begin src_gap_max = 0; snk_gap_max = 7; end
                default: begin src_gap_max = 7; snk_gap_max = 0; end
            endcase
            if (p == 1)
                holds_asked++;
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_sample(rand_sample(), (n == 0) ? 1'($urandom) : ($urandom_range(0, 49) == 0));
            wait_drained();
        end

        if (errors == 0)
            $display("iir_direct_form2_transposed test passed");
        else
            $display("iir_direct_form2_transposed test failed");
        $finish;
    end

endmodule

`default_nettype wire
